/* hw/rtl/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_BODY = 7'b0000010,
        MODE_ESC  = 7'b0000100,
        MODE_HEX0 = 7'b0001000,
        MODE_HEX1 = 7'b0010000,
        MODE_HEX2 = 7'b0100000,
        MODE_HEX3 = 7'b1000000
    } mode_t;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] CP_REPLACE = 16'hFFFD;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            h.value = b[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* hw/rtl/json_string_unescaper_unit.sv */
`timescale 1ns / 1ps
// Path: a beat accepted into the staging register is decoded into the result
// registers, and its first result byte is offered from there.
// Throughput: one input beat per cycle unless out_stall keeps the result buffer full;
// a \u escape giving two or three UTF-8 bytes holds the input while they drain.
// Reset (asynchronous, rst_n low) returns the decoder to idle, awaiting an opening
// quote, and empties the staging and result registers.

module json_string_unescaper_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last
);

    logic               stage_valid_reg;
    logic [7:0]         stage_byte_reg;
    logic               stage_eoi_reg;
    jsu_pkg::mode_t     mode_reg;
    jsu_pkg::mode_t     mode_next;
    logic [11:0]        code_accum_reg;
    logic [11:0]        code_accum_next;
    logic [7:0]         res_byte_reg [3];
    logic [7:0]         res_byte_next [3];
    logic [1:0]         res_status_reg;
    logic [1:0]         res_status_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic [1:0]         pos_reg;
    logic               buf_empty;
    logic               out_pop;
    logic               drains;
    logic               proc;
    logic               in_take;
    jsu_pkg::hex_t      hex;
    logic [15:0]        cp;

    assign buf_empty = (pos_reg == cnt_reg);
    assign out_valid = !buf_empty;
    assign out_pop   = out_valid && !out_stall;
    assign drains    = buf_empty || (out_pop && (pos_reg + 2'd1 == cnt_reg));
    assign proc      = stage_valid_reg && drains;
    assign in_stall  = stage_valid_reg && !drains;
    assign in_take   = in_valid && !in_stall;

    assign out_byte = res_byte_reg[pos_reg];
    assign status   = res_status_reg;
    assign last     = (pos_reg + 2'd1 == cnt_reg);

    assign hex = jsu_pkg::hex_decode(stage_byte_reg);
    assign cp  = {code_accum_reg, hex.value};

    always_comb
    begin
        logic [15:0] cpf;
        mode_next        = mode_reg;
        code_accum_next  = code_accum_reg;
        res_byte_next[0] = 8'h00;
        res_byte_next[1] = 8'h00;
        res_byte_next[2] = 8'h00;
        res_status_next  = jsu_pkg::ST_DATA;
        cnt_next         = 2'd0;
        cpf              = cp;
        if (mode_reg == jsu_pkg::MODE_IDLE)
        begin
            if (!stage_eoi_reg)
            begin
                if (stage_byte_reg == jsu_pkg::CH_QUOTE)
                begin
                    mode_next = jsu_pkg::MODE_BODY;
                end
                else
                begin
                    res_status_next = jsu_pkg::ST_ERROR;
                    cnt_next        = 2'd1;
                end
            end
        end
        else if (stage_eoi_reg)
        begin
            mode_next       = jsu_pkg::MODE_IDLE;
            code_accum_next = 12'd0;
            res_status_next = jsu_pkg::ST_ERROR;
            cnt_next        = 2'd1;
        end
        else
        begin
            case (mode_reg)
                jsu_pkg::MODE_BODY:
                begin
                    if (stage_byte_reg == jsu_pkg::CH_QUOTE)
                    begin
                        mode_next       = jsu_pkg::MODE_IDLE;
                        code_accum_next = 12'd0;
                        res_status_next = jsu_pkg::ST_DONE;
                        cnt_next        = 2'd1;
                    end
                    else if (stage_byte_reg == jsu_pkg::CH_BSLASH)
                    begin
                        mode_next = jsu_pkg::MODE_ESC;
                    end
                    else if (stage_byte_reg < jsu_pkg::CH_SPACE)
                    begin
                        mode_next       = jsu_pkg::MODE_IDLE;
                        code_accum_next = 12'd0;
                        res_status_next = jsu_pkg::ST_ERROR;
                        cnt_next        = 2'd1;
                    end
                    else
                    begin
                        res_byte_next[0] = stage_byte_reg;
                        cnt_next         = 2'd1;
                    end
                end
                jsu_pkg::MODE_ESC:
                begin
                    mode_next = jsu_pkg::MODE_BODY;
                    cnt_next  = 2'd1;
                    case (stage_byte_reg)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                            res_byte_next[0] = stage_byte_reg;
                        8'h62: res_byte_next[0] = 8'h08;
                        8'h66: res_byte_next[0] = 8'h0C;
                        8'h6E: res_byte_next[0] = 8'h0A;
                        8'h72: res_byte_next[0] = 8'h0D;
                        8'h74: res_byte_next[0] = 8'h09;
                        8'h75:
                        begin
                            mode_next       = jsu_pkg::MODE_HEX0;
                            code_accum_next = 12'd0;
                            cnt_next        = 2'd0;
                        end
                        default:
                        begin
                            mode_next       = jsu_pkg::MODE_IDLE;
                            code_accum_next = 12'd0;
                            res_status_next = jsu_pkg::ST_ERROR;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2:
                begin
                    if (!hex.ok)
                    begin
                        mode_next       = jsu_pkg::MODE_IDLE;
                        code_accum_next = 12'd0;
                        res_status_next = jsu_pkg::ST_ERROR;
                        cnt_next        = 2'd1;
                    end
                    else
                    begin
                        code_accum_next = cp[11:0];
                        mode_next = jsu_pkg::mode_t'({mode_reg[5:0], 1'b0});
                    end
                end
                jsu_pkg::MODE_HEX3:
                begin
                    if (!hex.ok)
                    begin
                        mode_next       = jsu_pkg::MODE_IDLE;
                        code_accum_next = 12'd0;
                        res_status_next = jsu_pkg::ST_ERROR;
                        cnt_next        = 2'd1;
                    end
                    else
                    begin
                        mode_next       = jsu_pkg::MODE_BODY;
                        code_accum_next = 12'd0;
                        if (cp[15:11] == 5'b11011)
                        begin
                            cpf = jsu_pkg::CP_REPLACE;
                        end
                        if (cpf[15:7] == 9'd0)
                        begin
                            res_byte_next[0] = cpf[7:0];
                            cnt_next         = 2'd1;
                        end
                        else if (cpf[15:11] == 5'd0)
                        begin
                            res_byte_next[0] = {3'b110, cpf[10:6]};
                            res_byte_next[1] = {2'b10, cpf[5:0]};
                            cnt_next         = 2'd2;
                        end
                        else
                        begin
                            res_byte_next[0] = {4'b1110, cpf[15:12]};
                            res_byte_next[1] = {2'b10, cpf[11:6]};
                            res_byte_next[2] = {2'b10, cpf[5:0]};
                            cnt_next         = 2'd3;
                        end
                    end
                end
                default:
                begin
                    mode_next       = jsu_pkg::MODE_IDLE;
                    code_accum_next = 12'd0;
                    res_status_next = jsu_pkg::ST_ERROR;
                    cnt_next        = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= jsu_pkg::MODE_IDLE;
            code_accum_reg  <= 12'd0;
            cnt_reg         <= 2'd0;
            pos_reg         <= 2'd0;
        end
        else
        begin
            if (in_take)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                mode_reg       <= mode_next;
                code_accum_reg <= code_accum_next;
                cnt_reg        <= cnt_next;
                pos_reg        <= 2'd0;
            end
            else if (out_pop)
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_byte_reg <= in_byte;
            stage_eoi_reg  <= end_of_input;
        end
        if (proc)
        begin
            res_byte_reg[0] <= res_byte_next[0];
            res_byte_reg[1] <= res_byte_next[1];
            res_byte_reg[2] <= res_byte_next[2];
            res_status_reg  <= res_status_next;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= cnt_reg)
        else $error("result pointer ran past the result count");

    a_ctrl_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != jsu_pkg::ST_DATA) |-> last)
        else $error("completion or error beat is not the final beat");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == jsu_pkg::MODE_IDLE) |-> (code_accum_reg == 12'd0))
        else $error("code accumulator not cleared in idle");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid_reg && out_valid))
        else $error("input stalled with nothing pending");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !proc) |=> (stage_valid_reg && $stable(stage_byte_reg)))
        else $error("staged beat lost before decode");

endmodule
